FILE: hdl/mtt_pkg.sv
package mtt_pkg;

	typedef enum logic [1:0] {
		KIND_CREATE  = 2'd0,
		KIND_DESTROY = 2'd1,
		KIND_TICK    = 2'd2,
		KIND_RSVD    = 2'd3
	} kind_t;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_BAD_SRC   = 2'd3;

	localparam logic [1:0] REG_SRC_VALID  = 2'd0;
	localparam logic [1:0] REG_ACTIVE_SRC = 2'd1;
	localparam logic [1:0] REG_TICK_NS    = 2'd2;

	localparam int TICK_W      = 30;
	localparam int DEC_W       = 11;
	localparam int PROD_W      = 63;
	localparam int RECIP_SHIFT = 51;

	localparam logic [TICK_W-1:0] TICK_RESET = 30'd1000000;
	localparam logic [TICK_W:0]   TICK_ROUND = 31'd999999;
	// ceil(2^51 / 1e6), exact floor division for 31-bit dividends
	localparam logic [31:0]       RECIP      = 32'd2251799814;
	localparam logic [DEC_W-1:0]  DEC_RESET  = 11'd1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_WALK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic               periodic;
		logic [31:0]        period;
		logic signed [33:0] rem;
	} entry_t;

	typedef struct packed {
		logic all;
		logic rem;
	} wr_en_t;

endpackage

FILE: hdl/multi_timer_table.sv
// multi_timer_table: a table of NUM_TIMERS one-shot or periodic millisecond timers.
// input channel (in_valid/in_ready) takes one beat per command: create, destroy
// or a tick interrupt. output channel (out_valid/out_ready) returns result beats,
// the final beat of each command marked by last.
// create searches the slot valid bits one per cycle and takes the first free
// slot; its result is loaded into the output register from S_FIN.
// destroy and a rejected tick go straight from the beat to S_FIN, which loads
// their result into the output register.
// an accepted tick walks every slot of the timer memory through one shared
// subtract/compare unit, one slot per cycle on the memory's single read port
// while the output does not stall; the last beat is loaded from S_FIN once
// every slot has been walked.
// in_ready is high only while the sequencer is idle; the next command is taken
// while the last result still waits in the output register.
// each fired timer gives one beat; the walk pauses when a fired beat finds the
// output register still full.
// the tick decrement ceil(tick_ns/1e6) is kept in a register recomputed every
// cycle by a reciprocal multiply.
// reset (arst_n low) empties the table, drops any pending result and restores
// the configuration registers; timer memory contents need no clearing.
module multi_timer_table #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [29:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic        periodic,
	input  logic [31:0] timeout_ms,
	input  logic [3:0]  timer_id,
	input  logic [7:0]  source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  slot,
	output logic        fired,
	output logic        last
);
	import mtt_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

	state_t state_q, state_d;

	logic              src_valid_q;
	logic [7:0]        active_src_q;
	logic [TICK_W-1:0] tick_q;
	logic [DEC_W-1:0]  dec_q;
	logic [TICK_W:0]   tick_sum;
	logic [PROD_W-1:0] dec_prod;

	logic [NUM_TIMERS-1:0] valid_q;
	logic [IW-1:0]         idx_q;
	logic                  cr_periodic_q;
	logic [31:0]           cr_timeout_q;
	logic [1:0]            fin_status_q;
	logic [3:0]            hold_slot_q;
	logic                  hold_fired_q;

	logic       out_valid_q;
	logic [1:0] status_q;
	logic [3:0] slot_q;
	logic       fired_q;
	logic       last_q;

	logic               accept;
	logic               out_free;
	logic               src_ok;
	logic               destroy_ok;
	logic [IW-1:0]      id_idx;
	logic [3:0]         idx_slot;
	logic signed [33:0] dec_ext;
	logic signed [33:0] rem_new;
	logic               fire_now;
	logic               stall;
	logic               walk_adv;
	logic               find_hit;
	logic               push;
	logic               fin_load;

	wr_en_t        wr_en;
	entry_t        wr_data;
	entry_t        rd_data;
	logic [IW-1:0] rd_addr;

	mtt_slot_mem #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign tick_sum = {1'b0, tick_q} + TICK_ROUND;
	assign dec_prod = PROD_W'(tick_sum) * PROD_W'(RECIP);

	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign src_ok     = src_valid_q && (source == active_src_q);
	assign id_idx     = IW'({{IW{1'b0}}, timer_id});
	assign destroy_ok = ({28'd0, timer_id} < 32'(NUM_TIMERS)) && valid_q[id_idx];
	assign idx_slot   = 4'({4'd0, idx_q});
	assign dec_ext    = $signed({23'd0, dec_q});
	assign rem_new    = rd_data.rem - dec_ext;

	assign fire_now = (state_q == S_WALK) && valid_q[idx_q] && (rem_new <= 34'sd0);
	assign stall    = fire_now && hold_fired_q && !out_free;
	assign walk_adv = (state_q == S_WALK) && !stall;
	assign find_hit = (state_q == S_FIND) && !valid_q[idx_q];
	assign push     = walk_adv && fire_now && hold_fired_q;
	assign fin_load = (state_q == S_FIN) && out_free;

	always_comb begin
		rd_addr = '0;
		if (state_q == S_WALK) begin
			rd_addr = walk_adv ? idx_q + IW'(1) : idx_q;
		end
	end

	always_comb begin
		wr_en.all        = find_hit;
		wr_en.rem        = find_hit || (walk_adv && valid_q[idx_q]);
		wr_data.periodic = cr_periodic_q;
		wr_data.period   = cr_timeout_q;
		if (find_hit) begin
			wr_data.rem = $signed({2'b00, cr_timeout_q});
		end else if (fire_now && rd_data.periodic) begin
			wr_data.rem = $signed({2'b00, rd_data.period});
		end else begin
			wr_data.rem = rem_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (kind)
						KIND_CREATE:  state_d = S_FIND;
						KIND_DESTROY: state_d = S_FIN;
						KIND_TICK:    state_d = src_ok ? S_WALK : S_FIN;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_FIND: begin
				if (find_hit || idx_q == LAST_IDX) begin
					state_d = S_FIN;
				end
			end
			S_WALK: begin
				if (walk_adv && idx_q == LAST_IDX) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid_q  <= 1'b0;
			active_src_q <= '0;
			tick_q       <= TICK_RESET;
			dec_q        <= DEC_RESET;
			valid_q      <= '0;
			hold_fired_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_VALID:  src_valid_q  <= cfg_data[0];
					REG_ACTIVE_SRC: active_src_q <= cfg_data[7:0];
					REG_TICK_NS:    tick_q       <= cfg_data;
					default:        ;
				endcase
			end
			dec_q <= dec_prod[RECIP_SHIFT +: DEC_W];

			if (accept && kind == KIND_DESTROY && destroy_ok) begin
				valid_q[id_idx] <= 1'b0;
			end
			if (find_hit) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (walk_adv && fire_now && !rd_data.periodic) begin
				valid_q[idx_q] <= 1'b0;
			end

			if (accept) begin
				hold_fired_q <= 1'b0;
			end else if (walk_adv && fire_now) begin
				hold_fired_q <= 1'b1;
			end

			if (push || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cr_periodic_q <= periodic;
			cr_timeout_q  <= timeout_ms;
			idx_q         <= '0;
			hold_slot_q   <= (kind == KIND_DESTROY) ? timer_id : 4'd0;
			case (kind)
				KIND_DESTROY: fin_status_q <= destroy_ok ? STAT_OK : STAT_NOT_FOUND;
				KIND_TICK:    fin_status_q <= src_ok ? STAT_OK : STAT_BAD_SRC;
				default:      fin_status_q <= STAT_OK;
			endcase
		end
		if (state_q == S_FIND) begin
			if (find_hit) begin
				hold_slot_q <= idx_slot;
			end else if (idx_q == LAST_IDX) begin
				fin_status_q <= STAT_FULL;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
		if (walk_adv) begin
			idx_q <= idx_q + IW'(1);
			if (fire_now) begin
				hold_slot_q <= idx_slot;
			end
		end
		if (push) begin
			status_q <= STAT_OK;
			slot_q   <= hold_slot_q;
			fired_q  <= 1'b1;
			last_q   <= 1'b0;
		end else if (fin_load) begin
			status_q <= fin_status_q;
			slot_q   <= hold_slot_q;
			fired_q  <= hold_fired_q;
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign fired     = fired_q;
	assign last      = last_q;

endmodule

FILE: hdl/mtt_slot_mem.sv
module mtt_slot_mem #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                          clk,
	input  mtt_pkg::wr_en_t               wr_en,
	input  logic [$clog2(NUM_TIMERS)-1:0] wr_addr,
	input  mtt_pkg::entry_t               wr_data,
	input  logic [$clog2(NUM_TIMERS)-1:0] rd_addr,
	output mtt_pkg::entry_t               rd_data
);
	import mtt_pkg::*;

	logic [32:0] cfg_mem [NUM_TIMERS];
	logic [33:0] rem_mem [NUM_TIMERS];
	logic [32:0] rd_cfg_q;
	logic [33:0] rd_rem_q;

	always_ff @(posedge clk) begin
		if (wr_en.all) begin
			cfg_mem[wr_addr] <= {wr_data.periodic, wr_data.period};
		end
		if (wr_en.rem) begin
			rem_mem[wr_addr] <= wr_data.rem;
		end
		rd_cfg_q <= cfg_mem[rd_addr];
		rd_rem_q <= rem_mem[rd_addr];
	end

	assign rd_data = {rd_cfg_q, rd_rem_q};

endmodule

FILE: hdl/mtt_checker.sv
module mtt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [3:0] slot,
	input logic       fired,
	input logic       last
);
	import mtt_pkg::*;

	// in_ready is low in the cycle after any beat of a real command
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind != KIND_RSVD) |=> !in_ready)
		else $error("in_ready high right after a command beat");

	// only fired beats may continue a command
	a_nonfired_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !fired) |-> last)
		else $error("non-fired result beat without last");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fired) |-> (status == STAT_OK))
		else $error("fired result beat with error status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(status) && $stable(slot) && $stable(fired) && $stable(last)))
		else $error("stalled result beat changed");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (.*);
